// File: rtl/core/nhs_pkg.sv
// ----------------------------------------------------------------------------
// nhs_pkg
// Types and constants shared by the network header splitter.
// ----------------------------------------------------------------------------
package nhs_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 10;

  localparam logic [ByteW-1:0] TypeMask   = 8'b0000_0011;
  localparam logic [ByteW-1:0] SecBit     = 8'b0000_0010;
  localparam logic [ByteW-1:0] RouteBit   = 8'b0000_0100;
  localparam logic [ByteW-1:0] DstIeeeBit = 8'b0000_1000;
  localparam logic [ByteW-1:0] SrcIeeeBit = 8'b0001_0000;

  localparam logic [PosW-1:0] FixedLen   = 10'd8;
  localparam logic [PosW-1:0] IeeeLen    = 10'd8;
  localparam logic [PosW-1:0] RelayBase  = 10'd2;
  localparam logic [PosW-1:0] PosMax     = 10'd1023;
  localparam logic [PosW-1:0] PosFcLow   = 10'd0;
  localparam logic [PosW-1:0] PosFcHigh  = 10'd1;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             frame_end;
  } nhs_in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             in_payload;
    logic             frame_done;
    logic             frame_ok;
    logic             security_enabled;
    logic [PosW-1:0]  header_length;
  } nhs_res_t;

endpackage

// File: rtl/core/nhs_in_if.sv
// ----------------------------------------------------------------------------
// nhs_in_if
// Byte channel into the splitter: valid/ready plus one frame byte.
// ----------------------------------------------------------------------------
interface nhs_in_if;

  logic                          valid;
  logic                          ready;
  logic [nhs_pkg::ByteW-1:0]     data_byte;
  logic                          frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);

endinterface

// File: rtl/core/nhs_out_if.sv
// ----------------------------------------------------------------------------
// nhs_out_if
// Tagged byte channel out of the splitter: valid/ready plus result fields.
// ----------------------------------------------------------------------------
interface nhs_out_if;

  logic                          valid;
  logic                          ready;
  logic [nhs_pkg::ByteW-1:0]     out_byte;
  logic                          in_payload;
  logic                          frame_done;
  logic                          frame_ok;
  logic                          security_enabled;
  logic [nhs_pkg::PosW-1:0]      header_length;

  modport source (output valid, output out_byte, output in_payload, output frame_done,
                  output frame_ok, output security_enabled, output header_length,
                  input ready);
  modport sink   (input valid, input out_byte, input in_payload, input frame_done,
                  input frame_ok, input security_enabled, input header_length,
                  output ready);

endinterface

// File: rtl/core/nhs_in_stage.sv
// ----------------------------------------------------------------------------
// nhs_in_stage
// Input register: holds one incoming byte until the parser takes it.
// ----------------------------------------------------------------------------
module nhs_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  nhs_pkg::nhs_in_t item_i,
  output logic             valid_o,
  input  logic             ready_i,
  output nhs_pkg::nhs_in_t item_o
);
  import nhs_pkg::*;

  logic    valid_q;
  nhs_in_t item_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

// File: rtl/core/nhs_parser.sv
// ----------------------------------------------------------------------------
// nhs_parser
// Header tracker: byte counter, flag capture and header length per byte.
// ----------------------------------------------------------------------------
module nhs_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  nhs_pkg::nhs_in_t  item_i,
  output nhs_pkg::nhs_res_t res_o
);
  import nhs_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic            type_bad_q, type_bad_d;
  logic            secure_q, secure_d;
  logic            route_q, route_d;
  logic [PosW-1:0] hdr_end_q, hdr_end_d;
  logic            end_known_q, end_known_d;

  logic [ByteW-1:0] b;
  logic             last;
  logic             payload;
  logic             ok;
  logic [PosW:0]    pos_next;

  assign b    = item_i.data_byte;
  assign last = item_i.frame_end;

  always_comb begin
    type_bad_d  = type_bad_q;
    secure_d    = secure_q;
    route_d     = route_q;
    hdr_end_d   = hdr_end_q;
    end_known_d = end_known_q;
    if (pos_q == PosFcLow) begin
      type_bad_d = |(b & TypeMask);
    end else if (pos_q == PosFcHigh) begin
      secure_d    = |(b & SecBit);
      route_d     = |(b & RouteBit);
      hdr_end_d   = FixedLen + (|(b & DstIeeeBit) ? IeeeLen : '0)
                             + (|(b & SrcIeeeBit) ? IeeeLen : '0);
      end_known_d = !(|(b & RouteBit));
    end else if (route_q && !end_known_q && (pos_q == hdr_end_q)) begin
      // relay list: RelayBase bytes, count byte included, plus two bytes per relay
      hdr_end_d   = hdr_end_q + RelayBase + {1'b0, b, 1'b0};
      end_known_d = 1'b1;
    end
  end

  assign pos_next = {1'b0, pos_q} + {{PosW{1'b0}}, 1'b1};
  assign payload  = !type_bad_d && end_known_d && (pos_q >= hdr_end_d);
  assign ok       = !type_bad_d && end_known_d && (pos_next >= {1'b0, hdr_end_d});

  always_comb begin
    res_o.out_byte         = b;
    res_o.in_payload       = payload;
    res_o.frame_done       = last;
    res_o.frame_ok         = last && ok;
    res_o.security_enabled = last && secure_d;
    res_o.header_length    = (last && ok) ? hdr_end_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      type_bad_q  <= 1'b0;
      secure_q    <= 1'b0;
      route_q     <= 1'b0;
      hdr_end_q   <= '0;
      end_known_q <= 1'b0;
    end else if (fire_i) begin
      if (last) begin
        pos_q       <= '0;
        type_bad_q  <= 1'b0;
        secure_q    <= 1'b0;
        route_q     <= 1'b0;
        hdr_end_q   <= '0;
        end_known_q <= 1'b0;
      end else begin
        pos_q       <= pos_d;
        type_bad_q  <= type_bad_d;
        secure_q    <= secure_d;
        route_q     <= route_d;
        hdr_end_q   <= hdr_end_d;
        end_known_q <= end_known_d;
      end
    end
  end

  assign pos_d = (pos_q < PosMax) ? pos_next[PosW-1:0] : pos_q;

endmodule

// File: rtl/core/nhs_out_stage.sv
// ----------------------------------------------------------------------------
// nhs_out_stage
// Result register: holds one tagged byte until the sink takes it.
// ----------------------------------------------------------------------------
module nhs_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  nhs_pkg::nhs_res_t res_i,
  output logic              valid_o,
  input  logic              ready_i,
  output nhs_pkg::nhs_res_t res_o
);
  import nhs_pkg::*;

  logic     valid_q;
  nhs_res_t res_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// File: rtl/core/nwk_header_splitter.sv
// ----------------------------------------------------------------------------
// nwk_header_splitter
// Tags each network-layer frame byte as header or payload and reports
// frame validity, security flag and header length on the last byte.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | item
//  in_i    | in  | valid / ready     | data_byte, frame_end
//  out_o   | out | valid / ready     | out_byte, in_payload, frame_done,
//          |     |                   | frame_ok, security_enabled, header_length
//
//  One item per cycle sustained; each byte passes the input register, then the
//  result register, with the header tracker between them.
//  Reset clears the header tracker and both valid flags; no warm-up.
//  A stall on out_o holds the result register and backs up through the
//  input register; each stage takes a new item in the cycle its old one leaves.
// ----------------------------------------------------------------------------
module nwk_header_splitter (
  input  logic      clk_i,
  input  logic      rst_ni,
  nhs_in_if.sink    in_i,
  nhs_out_if.source out_o
);
  import nhs_pkg::*;

  nhs_in_t  in_item;
  nhs_in_t  stage_item;
  nhs_res_t res_next;
  nhs_res_t res_out;
  logic     stage_valid;
  logic     stage_ready;
  logic     fire;

  assign in_item.data_byte = in_i.data_byte;
  assign in_item.frame_end = in_i.frame_end;

  nhs_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .valid_o (stage_valid),
    .ready_i (stage_ready),
    .item_o  (stage_item)
  );

  assign fire = stage_valid && stage_ready;

  nhs_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (stage_item),
    .res_o  (res_next)
  );

  nhs_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid),
    .ready_o (stage_ready),
    .res_i   (res_next),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res_out)
  );

  assign out_o.out_byte         = res_out.out_byte;
  assign out_o.in_payload       = res_out.in_payload;
  assign out_o.frame_done       = res_out.frame_done;
  assign out_o.frame_ok         = res_out.frame_ok;
  assign out_o.security_enabled = res_out.security_enabled;
  assign out_o.header_length    = res_out.header_length;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for nwk_header_splitter. Frames are queued byte by
// byte, driven on the input channel and tracked by a local header tracker
// that tags each accepted byte; tagged bytes from the output channel are
// compared against it in order. Runs directed corner frames, then random
// frames under several handshake load patterns and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

  import nhs_pkg::*;

  logic clk_i;
  logic rst_ni;

  nhs_in_if  in_if ();
  nhs_out_if out_if ();

  nwk_header_splitter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // load pattern: 0 none, 1 sender idle, 2 receiver stall, 3 both
  int unsigned phase      = 0;
  logic        long_hold  = 1'b0;
  logic        in_took    = 1'b0;
  int unsigned errors     = 0;
  int unsigned bytes_in   = 0;
  int unsigned bytes_out  = 0;
  int unsigned frames_all = 0;
  int unsigned frames_ok  = 0;

  nhs_in_t  pending_bytes[$];
  nhs_res_t exp_tags[$];

  // header tracker state
  logic [PosW-1:0] pos_q       = '0;
  logic            type_bad_q  = 1'b0;
  logic            secure_q    = 1'b0;
  logic            route_q     = 1'b0;
  logic [PosW-1:0] hdr_end_q   = '0;
  logic            end_known_q = 1'b0;

  function automatic nhs_res_t split_byte(nhs_in_t it);
    nhs_res_t        r;
    logic [ByteW-1:0] b;
    logic            pay;
    logic            ok;
    b = it.data_byte;
    if (pos_q == PosFcLow) begin
      type_bad_q = |(b & TypeMask);
    end else if (pos_q == PosFcHigh) begin
      secure_q    = |(b & SecBit);
      route_q     = |(b & RouteBit);
      hdr_end_q   = FixedLen + (|(b & DstIeeeBit) ? IeeeLen : '0)
                             + (|(b & SrcIeeeBit) ? IeeeLen : '0);
      end_known_q = !route_q;
    end else if (route_q && !end_known_q && pos_q == hdr_end_q) begin
      hdr_end_q   = hdr_end_q + RelayBase + {1'b0, b, 1'b0};
      end_known_q = 1'b1;
    end
    pay = !type_bad_q && end_known_q && (pos_q >= hdr_end_q);
    ok  = !type_bad_q && end_known_q && (({1'b0, pos_q} + 11'd1) >= {1'b0, hdr_end_q});
    r.out_byte         = b;
    r.in_payload       = pay;
    r.frame_done       = it.frame_end;
    r.frame_ok         = it.frame_end && ok;
    r.security_enabled = it.frame_end && secure_q;
    r.header_length    = (it.frame_end && ok) ? hdr_end_q : '0;
    if (it.frame_end) begin
      frames_all++;
      if (ok) frames_ok++;
      pos_q       = '0;
      type_bad_q  = 1'b0;
      secure_q    = 1'b0;
      route_q     = 1'b0;
      hdr_end_q   = '0;
      end_known_q = 1'b0;
    end else if (pos_q != PosMax) begin
      pos_q = pos_q + 1'b1;
    end
    return r;
  endfunction

  task automatic queue_frame(input logic [7:0] lo, input logic [7:0] hi, input int relay,
                             input int len, input int fill);
    nhs_in_t it;
    int      base;
    base = 8 + (hi[3] ? 8 : 0) + (hi[4] ? 8 : 0);
    for (int i = 0; i < len; i++) begin
      it.data_byte = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      if (i == 0) it.data_byte = lo;
      else if (i == 1) it.data_byte = hi;
      else if (hi[2] && i == base) it.data_byte = 8'(relay);
      it.frame_end = (i == len - 1);
      pending_bytes = {pending_bytes, it};
    end
  endtask

  task automatic queue_random_frame(output int len);
    logic [7:0] lo;
    logic [7:0] hi;
    int         base;
    int         relay;
    int         hdr;
    lo = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) != 0) lo[1:0] = 2'b00;
    hi    = 8'($urandom_range(0, 255));
    base  = 8 + (hi[3] ? 8 : 0) + (hi[4] ? 8 : 0);
    relay = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 3);
    hdr   = hi[2] ? base + 2 + 2 * relay : base;
    case ($urandom_range(0, 9))
      0: len = $urandom_range(1, hdr - 1);
      1: len = hdr;
      default: len = hdr + $urandom_range(1, 12);
    endcase
    queue_frame(lo, hi, relay, len, -1);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // driver: acceptance at the rising edge, new values at the falling edge
  always @(posedge clk_i) begin
    nhs_res_t tag;
    in_took = in_if.valid && in_if.ready;
    if (in_took) begin
      tag      = split_byte(pending_bytes.pop_front());
      exp_tags = {exp_tags, tag};
      bytes_in++;
    end
  end

  always @(negedge clk_i) begin
    int unsigned send_pct;
    int unsigned recv_pct;
    if (rst_ni) begin
      case (phase)
        1:       begin send_pct = 84; recv_pct = 0;  end
        2:       begin send_pct = 0;  recv_pct = 84; end
        3:       begin send_pct = 19; recv_pct = 19; end
        default: begin send_pct = 0;  recv_pct = 0;  end
      endcase
      if (!in_if.valid || in_took) begin
        if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_pct) begin
          in_if.valid     <= 1'b1;
          in_if.data_byte <= pending_bytes[0].data_byte;
          in_if.frame_end <= pending_bytes[0].frame_end;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= !long_hold && ($urandom_range(0, 99) >= recv_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    nhs_res_t want;
    if (out_if.valid && out_if.ready) begin
      bytes_out++;
      if (exp_tags.size() == 0) begin
        $error("result item with no expected item, out_byte %0d", out_if.out_byte);
        errors++;
      end else begin
        want = exp_tags.pop_front();
        check_field("out_byte", want.out_byte, out_if.out_byte);
        check_field("in_payload", want.in_payload, out_if.in_payload);
        check_field("frame_done", want.frame_done, out_if.frame_done);
        check_field("frame_ok", want.frame_ok, out_if.frame_ok);
        check_field("security_enabled", want.security_enabled, out_if.security_enabled);
        check_field("header_length", want.header_length, out_if.header_length);
      end
    end
  end

  // long output stall while the sender keeps offering
  initial begin
    wait (bytes_in >= 30);
    @(posedge clk_i);
    long_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    long_hold = 1'b0;
  end

  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int n;
    int len;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.frame_end = 1'b0;
    out_if.ready    = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    queue_frame(8'h00, 8'h00, 0, 1, -1);       // ends at frame control low
    queue_frame(8'h00, 8'h02, 0, 2, -1);       // ends at frame control high
    queue_frame(8'h03, 8'h00, 0, 10, -1);      // not a data frame
    queue_frame(8'h01, 8'h1E, 0, 3, -1);
    queue_frame(8'hFE, 8'h00, 0, 12, -1);
    queue_frame(8'h00, 8'h00, 0, 8, 255);      // empty payload
    queue_frame(8'h00, 8'h00, 0, 7, 0);        // one byte short
    queue_frame(8'hFC, 8'hFF, 0, 26, -1);      // all flags, relay count zero, empty payload
    queue_frame(8'h00, 8'h04, 3, 9, -1);       // ends on relay count byte
    queue_frame(8'h00, 8'h04, 3, 8, -1);       // ends before relay count byte
    queue_frame(8'h00, 8'h04, 3, 16, -1);
    queue_frame(8'h00, 8'h1E, 255, 540, -1);   // largest header
    queue_frame(8'h00, 8'hFF, 0, 40, 0);
    wait (pending_bytes.size() == 0 && exp_tags.size() == 0);

    for (int p = 0; p < 4; p++) begin
      @(posedge clk_i);
      phase = p;
      n = 0;
      while (n < 15) begin
        queue_random_frame(len);
        n += len;
      end
      wait (pending_bytes.size() == 0 && exp_tags.size() == 0);
    end

    repeat (10) @(posedge clk_i);
    $display("Covered %0d bytes in %0d frames (%0d valid, %0d invalid), %0d results seen,",
             bytes_in, frames_all, frames_ok, frames_all - frames_ok, bytes_out);
    $display("over idle-free, sender-idle, receiver-stall and mixed loads plus a long stall.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
